// File: rtl/aabb_frustum_cull_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frustum cull block
// Shared concurrent assertion forms, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_TOP_MACROS_SVH
`define AABB_FRUSTUM_CULL_TOP_MACROS_SVH

// check a property at each rising edge, ignored while reset is held
`define AFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("afc assertion failed");

// check a property at each rising edge, reset included
`define AFC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("afc assertion failed during reset");

`endif

// File: rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Types, widths and helpers shared by the frustum cull block.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int CHUNK_SIZE = 16;
    localparam int NUM_PLANES = 6;
    localparam int IDX_W      = 12;
    localparam int COEF_W     = 14;
    localparam int OFS_W      = 22;
    localparam int PLANE_W    = 64;
    localparam int CFG_IDX_W  = 3;

    // bit positions of the packed plane fields
    localparam int A_LSB = 50;
    localparam int B_LSB = 36;
    localparam int C_LSB = 22;

    // world coordinate must hold 2048 * CHUNK_SIZE as a signed value
    localparam int CW = IDX_W + $clog2(CHUNK_SIZE) + 1;
    localparam int PW = COEF_W + CW;
    localparam int SW = PW + 2;

    // box stage plus two stages per plane cell
    localparam int AFC_DEPTH = 2 * NUM_PLANES + 1;
    localparam int CNT_W     = $clog2(AFC_DEPTH + 1);

    typedef struct packed {
        logic          vld;
        logic          vis;
        logic [CW-1:0] lo_x;
        logic [CW-1:0] lo_y;
        logic [CW-1:0] lo_z;
        logic [CW-1:0] hi_x;
        logic [CW-1:0] hi_y;
        logic [CW-1:0] hi_z;
    } t_afc_bus;

    typedef struct packed {
        logic               we;
        logic [PLANE_W-1:0] data;
    } t_afc_wr;

    function automatic logic [CW-1:0] f_box_lo(input logic [IDX_W-1:0] idx);
        logic signed [CW-1:0] v;
        logic signed [CW-1:0] s;
        v = CW'($signed(idx));
        s = $signed(CW'(CHUNK_SIZE));
        return CW'(v * s);
    endfunction

    function automatic logic [CW-1:0] f_box_hi(input logic [CW-1:0] lo);
        logic signed [CW-1:0] s;
        s = $signed(CW'(CHUNK_SIZE));
        return CW'($signed(lo) + s);
    endfunction

endpackage

// File: rtl/afc_if.sv
// ----------------------------------------------------------------------------
// afc channel interfaces
// Valid/ready channels for box requests, cull responses and plane writes.
// ----------------------------------------------------------------------------
interface afc_req_if;
    import afc_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] chunk_x;
    logic [IDX_W-1:0] chunk_y;
    logic [IDX_W-1:0] chunk_z;

    modport source (output valid, output chunk_x, output chunk_y, output chunk_z,
                    input ready);
    modport sink   (input valid, input chunk_x, input chunk_y, input chunk_z,
                    output ready);
endinterface

interface afc_rsp_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, output visible, input ready);
    modport sink   (input valid, input visible, output ready);
endinterface

interface afc_cfg_if;
    import afc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PLANE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/afc_box.sv
// ----------------------------------------------------------------------------
// afc_box
// Register a request and expand chunk indices into box bounds.
// ----------------------------------------------------------------------------
module afc_box (
    input  logic              i_clk,
    input  logic              i_rst_n,
    afc_req_if.sink           i_req,
    output afc_pkg::t_afc_bus o_bus,
    input  logic              i_rdy
);
    import afc_pkg::*;

    t_afc_bus r_bus;
    t_afc_bus n_bus;
    logic     w_adv;

    assign w_adv     = !r_bus.vld || i_rdy;
    assign i_req.ready = w_adv;
    assign o_bus     = r_bus;

    always_comb begin
        n_bus      = r_bus;
        n_bus.vld  = i_req.valid;
        n_bus.vis  = 1'b1;
        n_bus.lo_x = f_box_lo(i_req.chunk_x);
        n_bus.lo_y = f_box_lo(i_req.chunk_y);
        n_bus.lo_z = f_box_lo(i_req.chunk_z);
        n_bus.hi_x = f_box_hi(n_bus.lo_x);
        n_bus.hi_y = f_box_hi(n_bus.lo_y);
        n_bus.hi_z = f_box_hi(n_bus.lo_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else if (w_adv) begin
            r_bus <= n_bus;
        end
    end

endmodule

// File: rtl/afc_cell.sv
// ----------------------------------------------------------------------------
// afc_cell
// One plane of the chain: hold the plane, test the box, pass it on.
// ----------------------------------------------------------------------------
module afc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  afc_pkg::t_afc_wr  i_wr,
    input  afc_pkg::t_afc_bus i_bus,
    output logic              o_rdy,
    output afc_pkg::t_afc_bus o_bus,
    input  logic              i_rdy
);
    import afc_pkg::*;

    logic [PLANE_W-1:0]   r_plane;
    t_afc_bus             r_a;
    t_afc_bus             r_b;
    t_afc_bus             n_b;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [PW-1:0] r_pz;

    logic signed [COEF_W-1:0] w_a;
    logic signed [COEF_W-1:0] w_b;
    logic signed [COEF_W-1:0] w_c;
    logic signed [OFS_W-1:0]  w_d;
    logic signed [CW-1:0]     w_x;
    logic signed [CW-1:0]     w_y;
    logic signed [CW-1:0]     w_z;
    logic signed [SW-1:0]     w_sum;
    logic                     w_a_adv;
    logic                     w_b_adv;

    assign w_a = $signed(r_plane[A_LSB +: COEF_W]);
    assign w_b = $signed(r_plane[B_LSB +: COEF_W]);
    assign w_c = $signed(r_plane[C_LSB +: COEF_W]);
    assign w_d = $signed(r_plane[OFS_W-1:0]);

    // pick the corner that maximizes the dot product
    assign w_x = $signed(w_a[COEF_W-1] ? i_bus.lo_x : i_bus.hi_x);
    assign w_y = $signed(w_b[COEF_W-1] ? i_bus.lo_y : i_bus.hi_y);
    assign w_z = $signed(w_c[COEF_W-1] ? i_bus.lo_z : i_bus.hi_z);

    assign w_b_adv = !r_b.vld || i_rdy;
    assign w_a_adv = !r_a.vld || w_b_adv;
    assign o_rdy   = w_a_adv;
    assign o_bus   = r_b;

    assign w_sum = SW'(r_px) + SW'(r_py) + SW'(r_pz) + SW'(w_d);

    always_comb begin
        n_b     = r_a;
        n_b.vis = r_a.vis && !w_sum[SW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_wr.we) begin
            r_plane <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
        end else if (w_a_adv) begin
            r_a  <= i_bus;
            r_px <= PW'(w_a) * PW'(w_x);
            r_py <= PW'(w_b) * PW'(w_y);
            r_pz <= PW'(w_c) * PW'(w_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.vld <= 1'b0;
        end else if (w_b_adv) begin
            r_b <= n_b;
        end
    end

endmodule

// File: rtl/aabb_frustum_cull_top.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_top
// Six-plane frustum cull of chunk boxes, one cell per plane.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  : one request per chunk, signed indices chunk_x/y/z. The box spans
//            index*CHUNK_SIZE to index*CHUNK_SIZE+CHUNK_SIZE on each axis.
//   o_rsp  : one response per request, in order; visible=0 means culled.
//   i_cfg  : plane writes, index 0..5 selects the plane, higher indexes are
//            dropped. Always ready. Write planes only while no request is in
//            flight.
//   Path:    a request passes the box register, then a multiply stage and
//            a sum stage in each of the six plane cells, to its response.
//   Throughput: one request per cycle while o_rsp.ready is high; each cell
//            takes a new box every cycle unless its output stage is held.
//   Up to 13 requests are held in flight.
//   Reset clears all planes to zero (every box visible) and empties the chain.
//   A stalled response holds; the chain keeps filling its empty stages and
//   drops i_req.ready once all 13 stages are full.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afc_req_if.sink   i_req,
    afc_rsp_if.source o_rsp,
    afc_cfg_if.sink   i_cfg
);
    import afc_pkg::*;

    t_afc_bus w_bus [NUM_PLANES+1];
    logic     w_rdy [NUM_PLANES+1];
    t_afc_wr  w_wr  [NUM_PLANES];

    assign i_cfg.ready         = 1'b1;
    assign w_rdy[NUM_PLANES]   = o_rsp.ready;
    assign o_rsp.valid         = w_bus[NUM_PLANES].vld;
    assign o_rsp.visible       = w_bus[NUM_PLANES].vis;

    afc_box u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_bus   (w_bus[0]),
        .i_rdy   (w_rdy[0])
    );

    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
        assign w_wr[k].we   = i_cfg.valid && i_cfg.ready &&
                              (i_cfg.index == CFG_IDX_W'(k));
        assign w_wr[k].data = i_cfg.data;

        afc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr[k]),
            .i_bus   (w_bus[k]),
            .o_rdy   (w_rdy[k]),
            .o_bus   (w_bus[k+1]),
            .i_rdy   (w_rdy[k+1])
        );
    end

endmodule

// File: rtl/afc_checker.sv
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks of the frustum cull block, bound to the top level.
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_top_macros.svh"

module afc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_visible,
    input logic i_cfg_valid,
    input logic i_cfg_ready
);
    import afc_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_cfgd;
    logic             w_in;
    logic             w_out;

    assign w_in  = i_req_valid && i_req_ready;
    assign w_out = i_rsp_valid && i_rsp_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_in && !w_out) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_out && !w_in) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_cfgd <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_valid && i_cfg_ready) begin
                r_cfgd <= 1'b1;
            end
        end
    end

    `AFC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_rsp_valid)
    `AFC_ASSERT(a_rsp_has_req, i_clk, i_rst_n, i_rsp_valid |-> r_cnt != '0)
    `AFC_ASSERT(a_depth, i_clk, i_rst_n, r_cnt <= CNT_W'(AFC_DEPTH))
    `AFC_ASSERT(a_zero_planes, i_clk, i_rst_n, (i_rsp_valid && !r_cfgd) |-> i_rsp_visible)
    `AFC_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_visible)))

endmodule

bind aabb_frustum_cull_top afc_checker u_afc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_visible (o_rsp.visible),
    .i_cfg_valid   (i_cfg.valid),
    .i_cfg_ready   (i_cfg.ready)
);
